[src/bstc_pkg.sv]
// Shared types, register codes and constants of the bad-sector table checker.
`default_nettype none

package bstc_pkg;

  // Default number of checked entries that one table may hold.
  localparam int unsigned MaxEntriesDefault = 126;
  // Default depth of the queue between the front and the back.
  localparam int unsigned QueueDepthDefault = 2;

  // Configuration port geometry.
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // Word value that marks the end of a table in both entry words.
  localparam logic [15:0] EndWord = 16'hffff;
  // Largest value the entry count field can show.
  localparam logic [6:0] CountSat = 7'd127;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    RegCylinders = 2'd0,
    RegHeads     = 2'd1,
    RegSectors   = 2'd2
  } bstc_reg_e;

  // Sequencer states of the back part.
  typedef enum logic {
    BackIdle,
    BackFinish
  } bstc_back_e;

  // Disk geometry as held in the configuration registers.
  typedef struct packed {
    logic [15:0] cylinder_count;
    logic [7:0]  head_count;
    logic [7:0]  sectors_per_track;
  } bstc_geom_t;

  // One table entry as it arrives.
  typedef struct packed {
    logic [15:0] cylinder;
    logic [15:0] track_sector;
    logic        first_entry;
  } bstc_in_t;

  // One checked result.
  typedef struct packed {
    logic [31:0] sector_number;
    logic        out_of_range;
    logic        out_of_order;
    logic        duplicate;
    logic        end_marker;
    logic        ignored;
    logic [6:0]  entry_count;
    logic        table_error;
  } bstc_out_t;

  // Classified entry passed from the front to the back.
  typedef struct packed {
    logic [23:0] track_index;
    logic [7:0]  sector;
    logic        out_of_range;
    logic        end_marker;
    logic        first_entry;
  } bstc_work_t;

endpackage

`default_nettype wire

[src/bstc_front.sv]
// Front part: classifies an entry and computes its linear track index.
`default_nettype none

module bstc_front import bstc_pkg::*; (
  input  bstc_in_t   item_i,
  input  bstc_geom_t geom_i,
  output bstc_work_t work_o
);

  logic [7:0]  track;
  logic [7:0]  sector;
  logic [23:0] cyl_tracks;

  assign track  = item_i.track_sector[15:8];
  assign sector = item_i.track_sector[7:0];

  // First multiply: cylinder times heads, plus the track.
  assign cyl_tracks = {8'b0, item_i.cylinder} * {16'b0, geom_i.head_count};

  always_comb begin
    work_o.track_index  = cyl_tracks + {16'b0, track};
    work_o.sector       = sector;
    // A zero register makes every coordinate of that kind out of range.
    work_o.out_of_range = (item_i.cylinder >= geom_i.cylinder_count) ||
                          (track >= geom_i.head_count) ||
                          (sector >= geom_i.sectors_per_track);
    work_o.end_marker   = (item_i.cylinder == EndWord) &&
                          (item_i.track_sector == EndWord);
    work_o.first_entry  = item_i.first_entry;
  end

endmodule

`default_nettype wire

[src/bstc_fifo.sv]
// Small register queue that decouples the front from the back.
`default_nettype none

module bstc_fifo import bstc_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  bstc_work_t wr_data_i,
  output logic       full_o,
  input  logic       rd_en_i,
  output bstc_work_t rd_data_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  bstc_work_t        mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

[src/bstc_back.sv]
// Back part: finishes the sector number, runs the table checks, holds the result.
`default_nettype none

module bstc_back import bstc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bstc_geom_t geom_i,
  input  bstc_work_t work_i,
  input  logic       work_empty_i,
  output logic       work_pop_o,
  output bstc_out_t  result_o,
  output logic       empty_o,
  input  logic       pop_i
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ExtW = (CntW > 7) ? CntW : 8;

  bstc_back_e       st_q, st_d;
  bstc_work_t       work_q;
  logic [31:0]      sn_q;
  logic [31:0]      scaled;

  logic [31:0]      prev_q, prev_d;
  logic             have_q, have_d;
  logic             warned_q, warned_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ended_q, ended_d;
  logic             err_q, err_d;

  bstc_out_t        out_q, out_d;
  logic             out_valid_q;
  logic             finish;

  // Effective table state after an optional start-of-table clear.
  logic             have_e, warned_e, ended_e, err_e;
  logic [CntW-1:0]  cnt_e;
  logic [31:0]      prev_e;
  logic             ign, order, dup;
  logic [ExtW-1:0]  cnt_ext;

  // Second multiply: track index times sectors per track, plus the sector.
  assign scaled = {8'b0, work_i.track_index} * {24'b0, geom_i.sectors_per_track};

  // Sequencer outputs.
  always_comb begin
    work_pop_o = 1'b0;
    finish     = 1'b0;
    case (st_q)
      BackIdle:   work_pop_o = !work_empty_i;
      BackFinish: finish     = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      BackIdle:   if (!work_empty_i) st_d = BackFinish;
      BackFinish: if (!out_valid_q || pop_i) st_d = BackIdle;
      default:    st_d = BackIdle;
    endcase
  end

  // Table checks and state update for the entry held in work_q.
  always_comb begin
    have_e   = work_q.first_entry ? 1'b0 : have_q;
    warned_e = work_q.first_entry ? 1'b0 : warned_q;
    ended_e  = work_q.first_entry ? 1'b0 : ended_q;
    err_e    = work_q.first_entry ? 1'b0 : err_q;
    cnt_e    = work_q.first_entry ? '0 : cnt_q;
    prev_e   = work_q.first_entry ? '0 : prev_q;

    ign   = ended_e || (cnt_e >= CntW'(MAX_ENTRIES));
    order = have_e && (sn_q < prev_e) && !warned_e;
    dup   = have_e && (sn_q == prev_e);

    have_d   = have_e;
    warned_d = warned_e;
    ended_d  = ended_e;
    err_d    = err_e;
    cnt_d    = cnt_e;
    prev_d   = prev_e;

    out_d               = '0;
    if (ign) begin
      out_d.ignored = 1'b1;
    end else if (work_q.end_marker) begin
      out_d.end_marker = 1'b1;
      ended_d          = 1'b1;
    end else begin
      out_d.sector_number = sn_q;
      out_d.out_of_range  = work_q.out_of_range;
      out_d.out_of_order  = order;
      out_d.duplicate     = dup;
      if (order) begin
        warned_d = 1'b1;
      end
      if (work_q.out_of_range || order || dup) begin
        err_d = 1'b1;
      end
      prev_d = sn_q;
      have_d = 1'b1;
      cnt_d  = cnt_e + 1'b1;
    end

    // The count field saturates when the table holds more than it can show.
    cnt_ext           = ExtW'(cnt_d);
    out_d.entry_count = (cnt_ext > ExtW'(CountSat)) ? CountSat : cnt_ext[6:0];
    out_d.table_error = err_d;
  end

  // Control and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BackIdle;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      have_q      <= 1'b0;
      warned_q    <= 1'b0;
      cnt_q       <= '0;
      ended_q     <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      st_q <= st_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        prev_q      <= prev_d;
        have_q      <= have_d;
        warned_q    <= warned_d;
        cnt_q       <= cnt_d;
        ended_q     <= ended_d;
        err_q       <= err_d;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      work_q <= work_i;
      sn_q   <= scaled + {24'b0, work_i.sector};
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

endmodule

`default_nettype wire

[src/bad_sector_table_checker_unit.sv]
// Top level of the bad-sector table checker: register file, front, queue and back.
//
//   Channel   Direction  Handshake                    Payload
//   --------  ---------  ---------------------------  ----------------------------
//   entry     in         push / full                  item_i (bstc_in_t)
//   result    out        empty / pop                  result_o (bstc_out_t)
//   config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// The back sequencer works on one entry at a time (second multiply, then the checks
// and state update). An accepted entry passes the queue, the work_q and sn_q registers
// and the result register before it shows on the result side; a waiting result holds the back.
// A queue of QUEUE_DEPTH entries lets the front accept while the result waits.
// Reset loads the default geometry and clears the table state at once.
`default_nettype none

module bad_sector_table_checker_unit import bstc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Entry channel.
  input  logic                push,
  output logic                full,
  input  bstc_in_t            item_i,
  // Result channel.
  output logic                empty,
  input  logic                pop,
  output bstc_out_t           result_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  bstc_geom_t geom_q;
  bstc_reg_e  reg_sel;
  logic       cfg_wr;
  bstc_work_t front_work;
  bstc_work_t queue_work;
  logic       queue_empty;
  logic       queue_pop;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = bstc_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.cylinder_count    <= 16'd1024;
      geom_q.head_count        <= 8'd16;
      geom_q.sectors_per_track <= 8'd63;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegCylinders: geom_q.cylinder_count    <= pwdata[15:0];
        RegHeads:     geom_q.head_count        <= pwdata[7:0];
        RegSectors:   geom_q.sectors_per_track <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegCylinders: prdata = {16'b0, geom_q.cylinder_count};
      RegHeads:     prdata = {24'b0, geom_q.head_count};
      RegSectors:   prdata = {24'b0, geom_q.sectors_per_track};
      default:      prdata = '0;
    endcase
  end

  bstc_front u_front (
    .item_i (item_i),
    .geom_i (geom_q),
    .work_o (front_work)
  );

  bstc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_work),
    .full_o    (full),
    .rd_en_i   (queue_pop),
    .rd_data_o (queue_work),
    .empty_o   (queue_empty)
  );

  bstc_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom_q),
    .work_i       (queue_work),
    .work_empty_i (queue_empty),
    .work_pop_o   (queue_pop),
    .result_o     (result_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

`default_nettype wire

[src/bstc_checker.sv]
// Port-level assertions for the bad-sector table checker, bound to the top level.
`default_nettype none

module bstc_checker import bstc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input bstc_out_t result_o
);

  // A waiting result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("held result changed or vanished");

  // A terminator is never also an ignored entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.end_marker && result_o.ignored))
    else $error("end marker and ignored both set");

  // Terminators and ignored entries carry no sector number and no check flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.end_marker || result_o.ignored)) |->
      (result_o.sector_number == '0 && !result_o.out_of_range &&
       !result_o.out_of_order && !result_o.duplicate))
    else $error("unchecked entry carries check results");

  // Any error in this entry shows in the table error flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.out_of_range || result_o.out_of_order ||
                result_o.duplicate)) |-> result_o.table_error)
    else $error("entry error missing from table error");

endmodule

bind bad_sector_table_checker_unit bstc_checker u_bstc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
